@@ design/apsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path solver: request
// codes and the fixed widths of the request, result and configuration words.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int REQ_W    = 2;
  localparam int NODE_W   = 4;
  localparam int WEIGHT_W = 16;
  localparam int CFG_W    = 16;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [CFG_W-1:0]    cfg_t;

  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_SOLVE = 2'd1;
  localparam req_t REQ_QUERY = 2'd2;

  localparam cfg_t NO_EDGE_RESET = 16'd800;

endpackage : apsp_pkg
`default_nettype wire

@@ design/apsp_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_req_if
// Request channel: one word carries a load, solve or query request.
// ----------------------------------------------------------------------------
interface apsp_req_if import apsp_pkg::*; ();
  logic    valid;
  logic    ready;
  req_t    req_type;
  node_t   src_node;
  node_t   dst_node;
  weight_t edge_weight;

  modport source (output valid, output req_type, output src_node, output dst_node,
                  output edge_weight, input ready);
  modport sink   (input valid, input req_type, input src_node, input dst_node,
                  input edge_weight, output ready);
endinterface : apsp_req_if
`default_nettype wire

@@ design/apsp_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_rsp_if
// Result channel: one word answers one query.
// ----------------------------------------------------------------------------
interface apsp_rsp_if import apsp_pkg::*; ();
  logic    valid;
  logic    ready;
  weight_t distance;
  node_t   next_hop;
  logic    reachable;

  modport source (output valid, output distance, output next_hop, output reachable,
                  input ready);
  modport sink   (input valid, input distance, input next_hop, input reachable,
                  output ready);
endinterface : apsp_rsp_if
`default_nettype wire

@@ design/apsp_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_store
// Distance and next-hop matrix: one write port and two registered read ports,
// each read port holding its data until it is read again.
// ----------------------------------------------------------------------------
module apsp_store #(
  parameter int DEPTH  = 256,
  parameter int DIST_W = 16,
  parameter int HOP_W  = 5
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DIST_W-1:0]        wr_dist,
  input  wire logic [HOP_W-1:0]         wr_hop,
  input  wire logic                     rd_a_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic      [DIST_W-1:0]        rd_a_dist,
  output logic      [HOP_W-1:0]         rd_a_hop,
  input  wire logic                     rd_b_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [DIST_W-1:0]        rd_b_dist,
  output logic      [HOP_W-1:0]         rd_b_hop
);

  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [HOP_W-1:0]  hop_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      hop_mem[wr_addr]  <= wr_hop;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_dist <= dist_mem[rd_a_addr];
      rd_a_hop  <= hop_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_dist <= dist_mem[rd_b_addr];
      rd_b_hop  <= hop_mem[rd_b_addr];
    end
  end

endmodule : apsp_store
`default_nettype wire

@@ design/all_pairs_shortest_path_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_solver
// Floyd-Warshall all-pairs shortest paths over a NODES x NODES weight matrix.
// ----------------------------------------------------------------------------
// A load word writes one edge weight; a weight equal to the no-edge
// register marks a missing edge. A query word reads the matrix store once
// into read port B, and its result word is loaded into the output register
// once that register is free; a further word is taken once that result has
// a place in the output register. A solve word runs the k,i,j relaxation in
// place and occupies the block through its final drain state: each relaxation
// reads the (k,j) and (i,j) entries through the two read ports of the matrix
// store and writes (i,j) back in the next cycle, and each row first fetches
// its (i,k) entry in a state of its own. Every entry must be loaded before a
// solve or a query touches it; the store has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_solver import apsp_pkg::*; #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_wr_en,
  input  wire cfg_t   cfg_wr_data,
  apsp_req_if.sink    in_item,
  apsp_rsp_if.source  out_item
);

  localparam int NB    = $clog2(NODES);
  localparam int DEPTH = NODES * NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int HB    = $clog2(NODES + 1);
  localparam int SW    = WEIGHT_BITS + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_ROW, ST_RUN, ST_DRAIN} state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [NB-1:0] r,
                                              input logic [NB-1:0] c);
    return AW'(r) * AW'(NODES) + AW'(c);
  endfunction

  state_t               state_r;
  logic [NB-1:0]        k_r, i_r, j_r;
  cfg_t                 no_edge_r;
  logic                 s_valid_r;
  logic [AW-1:0]        s_addr_r;
  logic [WEIGHT_BITS-1:0] ik_dist_r;
  logic [HB-1:0]        ik_hop_r;
  logic                 q_pend_r, q_in_r;
  logic                 out_valid_r;
  weight_t              out_dist_r;
  node_t                out_hop_r, out_hop_nxt;
  logic                 out_reach_r, out_reach_nxt;
  weight_t              out_dist_nxt;

  logic                   wr_en, rd_a_en, rd_b_en;
  logic [AW-1:0]          wr_addr, rd_a_addr, rd_b_addr;
  logic [WEIGHT_BITS-1:0] wr_dist, rd_a_dist, rd_b_dist;
  logic [HB-1:0]          wr_hop, rd_a_hop, rd_b_hop;

  logic          accept, in_range, load_we, out_free, relax_we;
  logic [NB-1:0] src_idx, dst_idx;
  logic [SW-1:0] sum;

  assign in_item.ready = (state_r == ST_IDLE) && !q_pend_r;
  assign accept  = in_item.valid && in_item.ready;
  assign in_range = (32'(in_item.src_node) < NODES) && (32'(in_item.dst_node) < NODES);
  assign src_idx = NB'(in_item.src_node);
  assign dst_idx = NB'(in_item.dst_node);
  assign load_we = accept && (in_item.req_type == REQ_LOAD) && in_range;
  assign out_free = !out_valid_r || out_item.ready;

  // Relaxation stage: port A holds (k,j), port B holds (i,j).
  assign sum = SW'(ik_dist_r) + SW'(rd_a_dist);
  assign relax_we = s_valid_r && (ik_hop_r != '0) && (rd_a_hop != '0) &&
                    ((rd_b_hop == '0) || (SW'(rd_b_dist) > sum));

  always_comb begin
    rd_a_en   = 1'b0;
    rd_a_addr = cell_addr(k_r, j_r);
    rd_b_en   = 1'b0;
    rd_b_addr = cell_addr(i_r, j_r);
    unique case (state_r)
      ST_ROW: begin
        rd_a_en   = 1'b1;
        rd_a_addr = cell_addr(i_r, k_r);
      end
      ST_RUN: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
      end
      ST_IDLE: begin
        if (accept && (in_item.req_type == REQ_QUERY)) begin
          rd_b_en   = 1'b1;
          rd_b_addr = in_range ? cell_addr(src_idx, dst_idx) : '0;
        end
      end
      ST_DRAIN: begin
      end
    endcase
  end

  always_comb begin
    if (s_valid_r) begin
      wr_en   = relax_we;
      wr_addr = s_addr_r;
      wr_dist = WEIGHT_BITS'(sum);
      wr_hop  = ik_hop_r;
    end else begin
      wr_en   = load_we;
      wr_addr = cell_addr(src_idx, dst_idx);
      wr_dist = WEIGHT_BITS'(in_item.edge_weight);
      wr_hop  = (in_item.edge_weight != no_edge_r) ? HB'(dst_idx) + HB'(1) : '0;
    end
  end

  apsp_store #(
    .DEPTH  (DEPTH),
    .DIST_W (WEIGHT_BITS),
    .HOP_W  (HB)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_dist   (wr_dist),
    .wr_hop    (wr_hop),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_dist (rd_a_dist),
    .rd_a_hop  (rd_a_hop),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_dist (rd_b_dist),
    .rd_b_hop  (rd_b_hop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_edge_r <= NO_EDGE_RESET;
    end else if (cfg_wr_en) begin
      no_edge_r <= cfg_wr_data;
    end
  end

  // Solve sequencer. The last write of a row lands while the next row fetches
  // its (i,k) entry, so no read of row k+1 can see a stale value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      k_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_item.req_type == REQ_SOLVE)) begin
            k_r     <= '0;
            i_r     <= '0;
            j_r     <= '0;
            state_r <= ST_ROW;
          end
        end
        ST_ROW: begin
          j_r     <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          s_valid_r <= 1'b1;
          s_addr_r  <= rd_b_addr;
          if (j_r == '0) begin
            ik_dist_r <= rd_a_dist;
            ik_hop_r  <= rd_a_hop;
          end
          if (j_r == NB'(NODES - 1)) begin
            j_r <= '0;
            if (i_r == NB'(NODES - 1)) begin
              i_r <= '0;
              if (k_r == NB'(NODES - 1)) begin
                k_r     <= '0;
                state_r <= ST_DRAIN;
              end else begin
                k_r     <= k_r + NB'(1);
                state_r <= ST_ROW;
              end
            end else begin
              i_r     <= i_r + NB'(1);
              state_r <= ST_ROW;
            end
          end else begin
            j_r <= j_r + NB'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Query path: the read data of port B stays put until the output word frees.
  always_comb begin
    out_reach_nxt = q_in_r && (rd_b_hop != '0);
    out_dist_nxt  = out_reach_nxt ? WEIGHT_W'(rd_b_dist) : '0;
    out_hop_nxt   = out_reach_nxt ? NODE_W'(rd_b_hop - HB'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_pend_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && (in_item.req_type == REQ_QUERY)) begin
        q_pend_r <= 1'b1;
        q_in_r   <= in_range;
      end else if (q_pend_r && out_free) begin
        q_pend_r <= 1'b0;
      end
      if (q_pend_r && out_free) begin
        out_valid_r <= 1'b1;
        out_dist_r  <= out_dist_nxt;
        out_hop_r   <= out_hop_nxt;
        out_reach_r <= out_reach_nxt;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.distance  = out_dist_r;
  assign out_item.next_hop  = out_hop_r;
  assign out_item.reachable = out_reach_r;

  a_no_query_during_solve : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !q_pend_r)
    else $error("query pending while a solve runs");

  a_relax_only_in_solve : assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> ((state_r == ST_ROW) || (state_r == ST_RUN) || (state_r == ST_DRAIN)))
    else $error("relaxation stage active outside a solve");

  a_no_load_on_relax : assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> !load_we)
    else $error("load and relaxation collide on the write port");

  a_result_from_query : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(q_pend_r))
    else $error("result word without a pending query");

  a_drain_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> $past(state_r == ST_RUN) && s_valid_r)
    else $error("drain entered without a final relaxation");

endmodule : all_pairs_shortest_path_solver
`default_nettype wire
